FILE: rtl/acfb_pkg.sv
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared constants, register indexes and AES helper functions.
// ----------------------------------------------------------------------------
package acfb_pkg;

    localparam int BlockBits = 128;
    localparam int BlockBytes = BlockBits / 8;
    localparam int Rounds = 10;
    localparam int CountWidth = 5;
    localparam int RoundWidth = 4;
    localparam int CfgIdxWidth = 3;

    localparam logic [CfgIdxWidth-1:0] REG_KEY_UPPER = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_LOWER = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_IV_UPPER  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_IV_LOWER  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_DECRYPT   = 3'd4;

    typedef logic [BlockBits-1:0] t_block;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [RoundWidth-1:0] round;
    } t_round_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // rcon for the key round that produces round key r (1..10)
    function automatic logic [7:0] rcon(input logic [RoundWidth-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: rtl/acfb_round.sv
// ----------------------------------------------------------------------------
// acfb_round
// Shared AES round unit: one cipher round and one key schedule round per cycle.
// ----------------------------------------------------------------------------
module acfb_round
    import acfb_pkg::*;
(
    input  logic        i_clk,
    input  t_round_ctrl i_ctrl,
    input  t_block      i_state,
    input  t_block      i_key,
    output t_block      o_state
);

    t_block r_state, n_state;
    t_block r_rkey, n_rkey;

    t_block     w_sub, w_shift, w_mix, w_next_key;
    logic [31:0] w_rot;

    // byte i of the block sits at bits [127-8i -: 8]
    always_comb begin
        for (int i = 0; i < BlockBytes; i++) begin
            w_sub[BlockBits-1-8*i -: 8] = SBOX[r_state[BlockBits-1-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_shift[BlockBits-1-8*(4*c+i) -: 8] =
                    w_sub[BlockBits-1-8*((((c+i) & 3)*4)+i) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = w_shift[BlockBits-1-32*c -: 8];
            a1 = w_shift[BlockBits-9-32*c -: 8];
            a2 = w_shift[BlockBits-17-32*c -: 8];
            a3 = w_shift[BlockBits-25-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            w_mix[BlockBits-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1),
                                             a1 ^ al ^ xtime(a1 ^ a2),
                                             a2 ^ al ^ xtime(a2 ^ a3),
                                             a3 ^ al ^ xtime(a3 ^ a0)};
        end
        // key schedule: next round key from the current one
        w_rot = {SBOX[r_rkey[23:16]], SBOX[r_rkey[15:8]], SBOX[r_rkey[7:0]],
                 SBOX[r_rkey[31:24]]} ^ {rcon(i_ctrl.round), 24'h0};
        w_next_key[127:96] = r_rkey[127:96] ^ w_rot;
        w_next_key[95:64]  = r_rkey[95:64] ^ w_next_key[127:96];
        w_next_key[63:32]  = r_rkey[63:32] ^ w_next_key[95:64];
        w_next_key[31:0]   = r_rkey[31:0] ^ w_next_key[63:32];

        n_state = r_state;
        n_rkey  = r_rkey;
        if (i_ctrl.load) begin
            n_state = i_state ^ i_key;
            n_rkey  = i_key;
        end else if (i_ctrl.step) begin
            n_rkey  = w_next_key;
            n_state = ((i_ctrl.round == RoundWidth'(Rounds)) ? w_shift : w_mix) ^ w_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey  <= n_rkey;
    end

    assign o_state = r_state;

endmodule

FILE: rtl/aes128_cfb_cipher.sv
// ----------------------------------------------------------------------------
// aes128_cfb_cipher
// AES-128 CFB-128 stream cipher, one 16-byte block per transfer.
// ----------------------------------------------------------------------------
// Channels: configuration writes on i_cfg_* (index 0/1 key, 2/3 IV, 4 decrypt
// mode); the user must write these only while the block is idle, as the block
// itself does not enforce this. Input blocks on the s_axis group, results on
// the m_axis group; tlast carries the final-block flag. After its input
// transfer loads the round unit, ten AES rounds follow through a single shared
// round unit whose key schedule runs alongside, then the DONE state forms the
// output. The next CFB block needs the full previous result, so one block is
// in flight at a time; s_axis_tready is high only while the block is idle.
// The result sits in an output register until the receiver takes it, so
// the next block can already run. If that block finishes while the
// register is still full it waits, and the input transfer after it is held.
// Reset clears key, IV and mode to zero and starts a new message from the IV.
// A short block (count below 16) or tlast ends the message; the next block
// reloads the IV.
// ----------------------------------------------------------------------------
module aes128_cfb_cipher
    import acfb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [135:0]           s_axis_tdata,  // data_upper, data_lower, byte_count, pad
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [135:0]           m_axis_tdata,  // result_upper, result_lower, result_count, pad
    output logic                   m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_st, n_st;
    logic [RoundWidth-1:0] r_round, n_round;
    logic [63:0]           r_key_u, r_key_l, r_iv_u, r_iv_l;
    logic                  r_dec, r_start, n_start;
    t_block                r_fb, n_fb, r_din, n_din, r_res, n_res;
    logic [CountWidth-1:0] r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic                  r_oval, n_oval;
    logic [CountWidth-1:0] r_ocnt, n_ocnt;
    logic                  r_olast, n_olast;
    t_round_ctrl           w_ctrl;
    t_block                w_ks, w_mask, w_in, w_out;
    logic [CountWidth-1:0] w_cnt_raw, w_cnt;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {3'd0, r_ocnt, r_res[63:0], r_res[127:64]};
    assign m_axis_tlast  = r_olast;

    assign w_in      = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_cnt_raw = s_axis_tdata[132:128];

    always_comb begin
        w_cnt = w_cnt_raw;
        if (w_cnt_raw == '0) w_cnt = CountWidth'(1);
        if (w_cnt_raw > CountWidth'(BlockBytes)) w_cnt = CountWidth'(BlockBytes);
    end

    always_comb begin
        for (int i = 0; i < BlockBytes; i++) begin
            w_mask[BlockBits-1-8*i -: 8] = (CountWidth'(i) < r_cnt) ? 8'hff : 8'h00;
        end
    end

    assign w_out = (w_ks ^ r_din) & w_mask;

    always_comb begin
        w_ctrl.load  = (r_st == ST_IDLE) && s_axis_tvalid;
        w_ctrl.step  = (r_st == ST_RUN);
        w_ctrl.round = r_round;
    end

    acfb_round u_round (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_state (r_start ? {r_iv_u, r_iv_l} : r_fb),
        .i_key   ({r_key_u, r_key_l}),
        .o_state (w_ks)
    );

    always_comb begin
        n_st = r_st;
        n_round = r_round;
        n_start = r_start;
        n_fb = r_fb;
        n_din = r_din;
        n_res = r_res;
        n_cnt = r_cnt;
        n_last = r_last;
        n_oval = r_oval && !m_axis_tready;
        n_ocnt = r_ocnt;
        n_olast = r_olast;
        case (r_st)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cnt   = w_cnt;
                    n_last  = s_axis_tlast || (w_cnt < CountWidth'(BlockBytes));
                    n_din   = w_in;
                    n_round = RoundWidth'(1);
                    n_st    = ST_RUN;
                end
            end
            ST_RUN: begin
                n_round = r_round + RoundWidth'(1);
                if (r_round == RoundWidth'(Rounds)) n_st = ST_DONE;
            end
            ST_DONE: begin
                // wait while the previous result is still unclaimed
                if (!r_oval || m_axis_tready) begin
                    n_res   = w_out;
                    n_ocnt  = r_cnt;
                    n_olast = r_last;
                    n_oval  = 1'b1;
                    n_din   = r_din & w_mask;
                    n_fb    = r_dec ? (r_din & w_mask) : w_out;
                    n_start = r_last;
                    n_st    = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_round <= '0;
            r_start <= 1'b1;
            r_oval  <= 1'b0;
            r_key_u <= '0;
            r_key_l <= '0;
            r_iv_u  <= '0;
            r_iv_l  <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_round <= n_round;
            r_oval  <= n_oval;
            // start flag drops once the IV has been taken by a block
            r_start <= (w_ctrl.load) ? 1'b0 : n_start;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_KEY_UPPER: r_key_u <= i_cfg_data;
                    REG_KEY_LOWER: r_key_l <= i_cfg_data;
                    REG_IV_UPPER:  r_iv_u  <= i_cfg_data;
                    REG_IV_LOWER:  r_iv_l  <= i_cfg_data;
                    REG_DECRYPT:   r_dec   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fb    <= n_fb;
        r_din   <= n_din;
        r_res   <= n_res;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
    end

endmodule

FILE: verif/tb_aes128_cfb_cipher.sv
// ----------------------------------------------------------------------------
// tb_aes128_cfb_cipher
// Drives AES-128 CFB-128 blocks through the cipher under several key, IV and
// direction settings, with random gaps and stalls. Each result is checked
// against a behavioral AES/CFB predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_aes128_cfb_cipher;
    import acfb_pkg::*;

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
        logic [4:0]  count;
        logic        final_blk;
    } t_cfb_result;

    class cfb_scoreboard;
        logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
        logic         decrypt;
        logic [127:0] feedback;
        logic [127:0] round_keys [11];
        bit           msg_start;
        t_cfb_result  pending [$];

        function new();
            key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
            decrypt = 1'b0;
            msg_start = 1'b1;
            feedback = '0;
            expand();
        endfunction

        function void expand();
            logic [31:0] w [44];
            logic [31:0] t;
            logic [7:0]  rc [10];
            rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
            w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
            w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
            for (int i = 4; i < 44; i++) begin
                t = w[i-1];
                if ((i % 4) == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                    t[31:24] = t[31:24] ^ rc[i/4-1];
                end
                w[i] = w[i-4] ^ t;
            end
            for (int r = 0; r < 11; r++)
                round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        endfunction

        function logic [7:0] dbl(logic [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [127:0] cipher(logic [127:0] blk);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, all;
            logic [127:0] v;
            v = blk ^ round_keys[0];
            for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
            for (int r = 1; r <= 10; r++) begin
                for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        s[c*4+i] = t[((c+i)%4)*4+i];
                if (r != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++)
                    s[i] = s[i] ^ round_keys[r][127-8*i -: 8];
            end
            for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
            return v;
        endfunction

        function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY_UPPER: begin key_hi = val; expand(); end
                REG_KEY_LOWER: begin key_lo = val; expand(); end
                REG_IV_UPPER:  iv_hi = val;
                REG_IV_LOWER:  iv_lo = val;
                REG_DECRYPT:   decrypt = val[0];
                default: ;
            endcase
        endfunction

        // accepted input block: advance the cfb state and queue the result
        function void note(logic [63:0] u, logic [63:0] l, logic [4:0] cnt, logic last);
            int           n;
            logic [127:0] mask, din, dout;
            t_cfb_result  r;
            n = (cnt == 0) ? 1 : (cnt > 16) ? 16 : cnt;
            if (msg_start) begin
                feedback = {iv_hi, iv_lo};
                msg_start = 0;
            end
            mask = ~128'd0 << (8 * (16 - n));
            din = {u, l} & mask;
            dout = (din ^ cipher(feedback)) & mask;
            feedback = decrypt ? din : dout;
            r.upper = dout[127:64];
            r.lower = dout[63:0];
            r.count = n[4:0];
            r.final_blk = last || (n < 16);
            if (r.final_blk) msg_start = 1;
            pending.push_back(r);
        endfunction

        function string check(logic [63:0] u, logic [63:0] l, logic [4:0] cnt, logic last);
            t_cfb_result e;
            if (pending.size() == 0) return "result with nothing expected";
            e = pending.pop_front();
            if (u !== e.upper)
                return $sformatf("upper %h, expected %h", u, e.upper);
            if (l !== e.lower)
                return $sformatf("lower %h, expected %h", l, e.lower);
            if (cnt !== e.count)
                return $sformatf("count %0d, expected %0d", cnt, e.count);
            if (last !== e.final_blk)
                return $sformatf("final %b, expected %b", last, e.final_blk);
            return "";
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CfgIdxWidth-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [135:0]           s_axis_tdata = '0;  // data_upper, data_lower, byte_count, pad
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [135:0]           m_axis_tdata;  // result_upper, result_lower, result_count, pad
    logic                   m_axis_tlast;

    cfb_scoreboard sb = new();
    int  errors = 0;
    bit  quiet = 0;
    bit  long_hold_req = 0;

    aes128_cfb_cipher dut (.*);

    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // receiver side: random stall bursts, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            msg = sb.check(m_axis_tdata[63:0], m_axis_tdata[127:64],
                           m_axis_tdata[132:128], m_axis_tlast);
            if (msg != "") report(msg);
        end
    end

    task automatic cfg_write(logic [CfgIdxWidth-1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_block(logic [63:0] u, logic [63:0] l, logic [4:0] cnt, logic last);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tdata = {3'b000, cnt, l, u};
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(u, l, cnt, last);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih,
                             logic [63:0] il, logic dec);
        cfg_write(REG_KEY_UPPER, kh);
        cfg_write(REG_KEY_LOWER, kl);
        cfg_write(REG_IV_UPPER, ih);
        cfg_write(REG_IV_LOWER, il);
        cfg_write(REG_DECRYPT, {63'd0, dec});
    endtask

    task automatic random_messages(int items);
        int sent, len;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any count, any final flag
                send_block(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'($urandom()));
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    send_block(rand64(), rand64(), 5'd16,
                               (k == len - 1) && $urandom_range(0, 1));
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_block(rand64(), rand64(), 5'($urandom_range(1, 15)), 1'($urandom()));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, count clamping, message ends
        configure('0, '0, '0, '0, 1'b0);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);
        send_block('1, '1, 5'd0, 1'b0);
        send_block('1, '1, 5'd1, 1'b0);
        send_block('1, '1, 5'd15, 1'b0);
        send_block('1, '1, 5'd17, 1'b0);
        send_block('1, '1, 5'd31, 1'b1);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b1);
        send_block('0, '1, 5'd16, 1'b0);
        send_block('1, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd7, 1'b0);
        drain();
        configure('1, '1, '1, '1, 1'b1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);
        send_block('1, '1, 5'd0, 1'b1);
        send_block('0, '1, 5'd31, 1'b0);
        send_block('1, '0, 5'd16, 1'b0);
        send_block('1, '1, 5'd9, 1'b0);
        drain();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: configure('0, '0, '0, '0, 1'b0);
                1: configure('1, '1, '1, '1, 1'b1);
                2: configure('1, '0, '0, '1, 1'b0);
                default: configure(rand64(), rand64(), rand64(), rand64(), p[0]);
            endcase
            if (p == 6) quiet = 1;
            if (p == 3) long_hold_req = 1;
            random_messages(200);
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (sb.pending.size() != 0) report("results still expected at the end");
        if (errors == 0) begin
            $display("aes128_cfb_cipher test passed");
        end else begin
            $display("aes128_cfb_cipher test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("aes128_cfb_cipher test failed");
        $finish;
    end

endmodule
